/* rtl/core/assert_macros.svh */
// Assertion macros used by the allocator top level; empty bodies under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/ffha_pkg.sv */
// Types and constants of the first-fit heap allocator.
package ffha_pkg;

   typedef struct packed {
      logic        mark;
      logic        taken;
      logic [15:0] size;
      logic [15:0] prev;
      logic [15:0] next;
      logic        has_prev;
      logic        has_next;
   } hdr_type;

   localparam logic OP_ALLOC = 1'b0;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_LEN   = 2'd1;
   localparam logic [1:0] ST_NOT_HDR   = 2'd2;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_CHK, S_A_FIXN, S_A_WRB, S_F_CHK, S_F_PCHK,
      S_F_PFIX, S_F_NRD, S_F_NCHK, S_F_NFIX, S_RSP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_CLEAR, CMD_ACCEPT, CMD_A_CHK, CMD_A_FIXN, CMD_A_WRB,
      CMD_F_CHK, CMD_F_PCHK, CMD_F_PFIX, CMD_F_NRD, CMD_F_NCHK, CMD_F_NFIX
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic req_alloc;
      logic bad_len;
      logic bad_off;
      logic fit;
      logic mark;
      logic taken;
      logic has_prev;
      logic has_next;
      logic b_has_next;
   } dp_status_type;

endpackage

/* rtl/core/ffha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/ffha_ctrl.sv */
// Controller state machine of the heap allocator.
module ffha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_ready,
   input  ffha_pkg::dp_status_type status,
   output ffha_pkg::cmd_type       cmd,
   output logic                   req_ready,
   output logic                   rsp_valid
);
   import ffha_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (status.clr_done) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               if (status.req_alloc) state_in = status.bad_len ? S_RSP : S_A_CHK;
               else                  state_in = status.bad_off ? S_RSP : S_F_CHK;
            end
         end
         S_A_CHK: begin
            if (status.fit)           state_in = status.has_next ? S_A_FIXN : S_A_WRB;
            else if (!status.has_next) state_in = S_RSP;
         end
         S_A_FIXN: state_in = S_A_WRB;
         S_A_WRB:  state_in = S_RSP;
         S_F_CHK: begin
            if (!status.mark || !status.taken) state_in = S_RSP;
            else if (status.has_prev)          state_in = S_F_PCHK;
            else if (status.has_next)          state_in = S_F_NCHK;
            else                               state_in = S_RSP;
         end
         S_F_PCHK: begin
            if (!status.b_has_next) state_in = S_RSP;
            else if (!status.taken) state_in = S_F_PFIX;
            else                    state_in = S_F_NCHK;
         end
         S_F_PFIX: state_in = S_F_NRD;
         S_F_NRD:  state_in = S_F_NCHK;
         S_F_NCHK: state_in = (!status.taken && status.has_next) ? S_F_NFIX : S_RSP;
         S_F_NFIX: state_in = S_RSP;
         S_RSP:    if (rsp_ready) state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_CLEAR:  cmd = CMD_CLEAR;
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = CMD_ACCEPT;
         end
         S_A_CHK:  cmd = CMD_A_CHK;
         S_A_FIXN: cmd = CMD_A_FIXN;
         S_A_WRB:  cmd = CMD_A_WRB;
         S_F_CHK:  cmd = CMD_F_CHK;
         S_F_PCHK: cmd = CMD_F_PCHK;
         S_F_PFIX: cmd = CMD_F_PFIX;
         S_F_NRD:  cmd = CMD_F_NRD;
         S_F_NCHK: cmd = CMD_F_NCHK;
         S_F_NFIX: cmd = CMD_F_NFIX;
         S_RSP:    rsp_valid = 1'b1;
         default:  cmd = CMD_NONE;
      endcase
   end
endmodule

/* rtl/core/ffha_datapath.sv */
// Datapath of the heap allocator: header store, pointers, counters, result word.
module ffha_datapath #(
   parameter int POOL_BYTES   = 4096,
   parameter int HEADER_BYTES = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ffha_pkg::cmd_type        cmd,
   input  logic                    req_operation,
   input  logic [15:0]             req_request_length,
   input  logic [15:0]             req_data_offset,
   output ffha_pkg::dp_status_type  status,
   output logic [1:0]              rsp_status,
   output logic [15:0]             rsp_granted_offset,
   output logic [12:0]             rsp_block_count,
   output logic [15:0]             rsp_used_bytes
);
   import ffha_pkg::*;

   localparam int STORE_BYTES = ((POOL_BYTES + 3) / 4) * 4;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int HW          = $bits(hdr_type);
   localparam logic [15:0] HDR       = 16'(HEADER_BYTES);
   localparam logic [17:0] STORE18   = 18'(STORE_BYTES);
   localparam logic [16:0] STORE17   = 17'(STORE_BYTES);
   localparam logic [16:0] POOL17    = 17'(POOL_BYTES);
   localparam logic [15:0] INIT_SIZE = 16'(STORE_BYTES - HEADER_BYTES);
   localparam logic [AW-1:0] LAST    = AW'(STORE_BYTES - 1);

   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] nn_ff, nn_in;
   logic [15:0]   lenr_ff, lenr_in;
   hdr_type       b_ff, b_in;
   hdr_type       c_ff, c_in;
   logic [12:0]   count_ff, count_in;
   logic [15:0]   used_ff, used_in;
   logic [1:0]    st_ff, st_in;
   logic [15:0]   grant_ff, grant_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   hdr_type       wr_data, rd;
   logic [HW-1:0] rd_raw;

   logic [16:0]   len_sum, need;
   logic [15:0]   lenr_new, h_full, cur16;
   logic [17:0]   rem_full;
   logic [AW-1:0] rem;
   logic          fit;

   ffha_ram #(.WIDTH(HW), .DEPTH(STORE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );
   assign rd = hdr_type'(rd_raw);

   // request decode
   assign len_sum  = {1'b0, req_request_length} + 17'd3;
   assign lenr_new = {len_sum[15:2], 2'b00};
   assign h_full   = req_data_offset - HDR;

   // walk step
   assign need     = {1'b0, lenr_ff} + {1'b0, HDR};
   assign rem_full = 18'(cur_ff) + {2'b00, HDR} + {2'b00, lenr_ff};
   assign rem      = rem_full[AW-1:0];
   assign cur16    = 16'(cur_ff);
   assign fit      = !rd.taken && ({1'b0, rd.size} >= need) && (rem_full < STORE18);

   always_comb begin
      status.clr_done   = (clr_ff == LAST);
      status.req_alloc  = (req_operation == OP_ALLOC);
      status.bad_len    = (req_request_length == 16'd0) ||
                          ({1'b0, req_request_length} >= POOL17);
      status.bad_off    = ({1'b0, req_data_offset} < {1'b0, HDR}) ||
                          ({1'b0, req_data_offset} > STORE17);
      status.fit        = fit;
      status.mark       = rd.mark;
      status.taken      = rd.taken;
      status.has_prev   = rd.has_prev;
      status.has_next   = rd.has_next;
      status.b_has_next = b_ff.has_next;
   end

   always_comb begin
      clr_in   = clr_ff;
      cur_in   = cur_ff;
      nn_in    = nn_ff;
      lenr_in  = lenr_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      count_in = count_ff;
      used_in  = used_ff;
      st_in    = st_ff;
      grant_in = grant_ff;
      wr_en    = 1'b0;
      wr_addr  = cur_ff;
      wr_data  = rd;
      rd_addr  = '0;
      case (cmd)
         CMD_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == '0) begin
               wr_data.mark = 1'b1;
               wr_data.size = INIT_SIZE;
            end
            clr_in = clr_ff + AW'(1);
         end
         CMD_ACCEPT: begin
            st_in    = ST_OK;
            grant_in = '0;
            lenr_in  = lenr_new;
            if (status.req_alloc) begin
               cur_in  = '0;
               rd_addr = '0;
               if (status.bad_len) st_in = ST_BAD_LEN;
            end else begin
               cur_in  = h_full[AW-1:0];
               rd_addr = h_full[AW-1:0];
               if (status.bad_off) st_in = ST_NOT_HDR;
            end
         end
         CMD_A_CHK: begin
            if (fit) begin
               b_in             = rd;
               wr_en            = 1'b1;
               wr_addr          = rem;
               wr_data.mark     = 1'b1;
               wr_data.taken    = 1'b0;
               wr_data.size     = rd.size - lenr_ff - HDR;
               wr_data.prev     = cur16;
               wr_data.has_prev = 1'b1;
               wr_data.next     = rd.next;
               wr_data.has_next = rd.has_next;
               rd_addr          = rd.next[AW-1:0];
            end else if (rd.has_next) begin
               cur_in  = rd.next[AW-1:0];
               rd_addr = rd.next[AW-1:0];
            end else begin
               st_in = ST_BAD_LEN;
            end
         end
         CMD_A_FIXN: begin
            wr_en            = 1'b1;
            wr_addr          = b_ff.next[AW-1:0];
            wr_data.prev     = 16'(rem);
            wr_data.has_prev = 1'b1;
         end
         CMD_A_WRB: begin
            wr_en            = 1'b1;
            wr_addr          = cur_ff;
            wr_data          = b_ff;
            wr_data.taken    = 1'b1;
            wr_data.next     = 16'(rem);
            wr_data.has_next = 1'b1;
            wr_data.size     = lenr_ff;
            count_in         = count_ff + 13'd1;
            used_in          = used_ff + lenr_ff;
            grant_in         = cur16 + HDR;
         end
         CMD_F_CHK: begin
            if (!rd.mark) begin
               st_in = ST_NOT_HDR;
            end else if (!rd.taken) begin
               st_in = ST_NOT_ALLOC;
            end else begin
               wr_en         = 1'b1;
               wr_addr       = cur_ff;
               wr_data.taken = 1'b0;
               b_in          = wr_data;
               c_in          = wr_data;
               used_in       = used_ff - rd.size;
               rd_addr       = rd.has_prev ? rd.prev[AW-1:0] : rd.next[AW-1:0];
            end
         end
         CMD_F_PCHK: begin
            // rd holds the previous block
            if (!rd.taken) begin
               wr_en            = 1'b1;
               wr_addr          = b_ff.prev[AW-1:0];
               wr_data.size     = rd.size + b_ff.size + HDR;
               wr_data.next     = b_ff.next;
               wr_data.has_next = b_ff.has_next;
               c_in             = wr_data;
               cur_in           = b_ff.prev[AW-1:0];
               count_in         = count_ff - 13'd1;
            end
            rd_addr = b_ff.next[AW-1:0];
         end
         CMD_F_PFIX: begin
            wr_en            = 1'b1;
            wr_addr          = b_ff.next[AW-1:0];
            wr_data.prev     = b_ff.prev;
            wr_data.has_prev = 1'b1;
         end
         CMD_F_NRD: begin
            rd_addr = c_ff.next[AW-1:0];
         end
         CMD_F_NCHK: begin
            // rd holds the next block
            if (!rd.taken) begin
               wr_en            = 1'b1;
               wr_addr          = cur_ff;
               wr_data          = c_ff;
               wr_data.size     = c_ff.size + rd.size + HDR;
               wr_data.next     = rd.next;
               wr_data.has_next = rd.has_next;
               count_in         = count_ff - 13'd1;
               nn_in            = rd.next[AW-1:0];
               rd_addr          = rd.next[AW-1:0];
            end
         end
         CMD_F_NFIX: begin
            wr_en            = 1'b1;
            wr_addr          = nn_ff;
            wr_data.prev     = cur16;
            wr_data.has_prev = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff   <= '0;
         count_ff <= 13'd1;
         used_ff  <= '0;
      end else begin
         clr_ff   <= clr_in;
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      nn_ff    <= nn_in;
      lenr_ff  <= lenr_in;
      b_ff     <= b_in;
      c_ff     <= c_in;
      st_ff    <= st_in;
      grant_ff <= grant_in;
   end

   assign rsp_status         = st_ff;
   assign rsp_granted_offset = grant_ff;
   assign rsp_block_count    = count_ff;
   assign rsp_used_bytes     = used_ff;
endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// First-fit heap allocator: one request in flight, result held until taken.
// Allocate: accept, a check of each header visited, the split writes, then the result.
// Free: at most one header write and one registered read per cycle.
// Out-of-range lengths and offsets answer the cycle after the accept.
// Reset (synchronous, high) starts a pass that clears one header word per cycle.
// A new request is accepted only once the result of the last one is taken.
`include "assert_macros.svh"
module first_fit_heap_allocator #(
   parameter int POOL_BYTES   = 4096,
   parameter int HEADER_BYTES = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [15:0] req_request_length,
   input  logic [15:0] req_data_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_offset,
   output logic [12:0] rsp_block_count,
   output logic [15:0] rsp_used_bytes
);
   import ffha_pkg::*;

   cmd_type       cmd;
   dp_status_type status;

   // sequencer: walks the chain and orders the header writes
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid)
   );

   // header store, pointers and the counters reported in every result word
   ffha_datapath #(
      .POOL_BYTES   (POOL_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_operation),
      .req_request_length (req_request_length),
      .req_data_offset    (req_data_offset),
      .status             (status),
      .rsp_status         (rsp_status),
      .rsp_granted_offset (rsp_granted_offset),
      .rsp_block_count    (rsp_block_count),
      .rsp_used_bytes     (rsp_used_bytes)
   );

   // one word in flight: never ready while a result is pending
   `ASSERT_ALWAYS(a_ready_xor_rsp, clock, reset, !(req_ready && rsp_valid))
   // accepted word keeps the block busy next cycle
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // failures never report a granted offset
   `ASSERT_IMPL(a_fail_no_grant, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_granted_offset == 16'd0)
endmodule

/* sim/tb_first_fit_heap_allocator.sv */
// Testbench for the first-fit heap allocator: predicted results checked word by word.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator;
   import ffha_pkg::*;

   localparam int POOL = 4096;
   localparam int HDR = 12;
   localparam int STORE = ((POOL + 3) / 4) * 4;
   localparam logic [7:0] MARK = 8'hAA;
   localparam logic OP_FREE = 1'b1;
   localparam int HOLD_CYCLES = 400;
   // watchdog: clearing pass plus worst walk over the headers and long stalls
   localparam int STALL_LIMIT = 60000;

   typedef struct {
      logic [7:0]  mark;
      logic [7:0]  taken;
      logic [15:0] size;
      logic [15:0] prev;
      logic [15:0] next;
      bit          has_prev;
      bit          has_next;
   } shadow_hdr_type;

   typedef struct packed {
      logic        op;
      logic [15:0] len;
      logic [15:0] off;
   } request_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted;
      logic [12:0] count;
      logic [15:0] used;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = 1'b0;
   logic [15:0] req_request_length = '0;
   logic [15:0] req_data_offset = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [15:0] rsp_granted_offset;
   logic [12:0] rsp_block_count;
   logic [15:0] rsp_used_bytes;

   first_fit_heap_allocator DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow heap state
   shadow_hdr_type heap [STORE];
   logic [12:0] n_blocks;
   logic [15:0] n_used;

   request_type pending_words [$];
   outcome_type expected_outcomes [$];
   logic [15:0] live_offsets [$];
   int fail_count = 0;
   int idle_cycles = 0;
   bit quiet_phase = 0;     // no random idling on either side
   int hold_requests = 0;   // bumped to start one long receiver hold-off
   int holds_taken = 0;
   bit pause_req = 0;       // sender stops until the pipeline drains

   // acceptance flag sampled at the rising edge
   bit req_ready_seen = 0;

   function automatic outcome_type mk(logic [1:0] st, logic [15:0] g);
      outcome_type o;
      o.status = st; o.granted = g; o.count = n_blocks; o.used = n_used;
      return o;
   endfunction

   function automatic outcome_type heap_alloc(logic [15:0] len_in);
      int len, cur, guard, rem;
      bit alive;
      alive = 1; cur = 0; guard = 0;
      if (len_in == 0 || len_in >= POOL) return mk(ST_BAD_LEN, 16'd0);
      len = ((int'(len_in) + 3) / 4) * 4;
      while (alive && cur < STORE && guard <= STORE) begin
         if (heap[cur].taken != MARK && heap[cur].size >= len + HDR) begin
            rem = cur + HDR + len;
            if (rem < STORE) begin
               heap[rem].mark = MARK;
               heap[rem].taken = 0;
               heap[rem].size = 16'(heap[cur].size - len - HDR);
               heap[rem].prev = 16'(cur);
               heap[rem].has_prev = 1;
               heap[rem].next = heap[cur].next;
               heap[rem].has_next = heap[cur].has_next;
               if (heap[rem].has_next && heap[rem].next < STORE) begin
                  heap[heap[rem].next].prev = 16'(rem);
                  heap[heap[rem].next].has_prev = 1;
               end
               heap[cur].taken = MARK;
               heap[cur].next = 16'(rem);
               heap[cur].has_next = 1;
               heap[cur].size = 16'(len);
               n_blocks = n_blocks + 13'd1;
               n_used = n_used + 16'(len);
               return mk(ST_OK, 16'(cur + HDR));
            end
         end
         alive = heap[cur].has_next;
         cur = int'(heap[cur].next);
         guard++;
      end
      return mk(ST_BAD_LEN, 16'd0);
   endfunction

   function automatic outcome_type heap_free(logic [15:0] off);
      int h, cur, nb;
      bit merged;
      merged = 0;
      if (off < HDR || off > STORE) return mk(ST_NOT_HDR, 16'd0);
      h = int'(off) - HDR;
      if (h >= STORE || heap[h].mark != MARK) return mk(ST_NOT_HDR, 16'd0);
      if (heap[h].taken != MARK) return mk(ST_NOT_ALLOC, 16'd0);
      heap[h].taken = 0;
      n_used = n_used - heap[h].size;
      cur = h;
      if (heap[h].has_prev && heap[h].prev < STORE && heap[heap[h].prev].taken != MARK) begin
         heap[heap[h].prev].size = 16'(heap[heap[h].prev].size + heap[h].size + HDR);
         heap[heap[h].prev].next = heap[h].next;
         heap[heap[h].prev].has_next = heap[h].has_next;
         if (heap[h].has_next && heap[h].next < STORE) begin
            heap[heap[h].next].prev = heap[h].prev;
            heap[heap[h].next].has_prev = 1;
         end
         n_blocks = n_blocks - 13'd1;
         merged = 1;
         cur = int'(heap[h].prev);
      end
      if (heap[h].has_next) begin
         nb = int'(heap[cur].next);
         if (heap[cur].has_next && nb < STORE && heap[nb].taken != MARK) begin
            heap[cur].size = 16'(heap[cur].size + heap[nb].size + HDR);
            heap[cur].next = heap[nb].next;
            heap[cur].has_next = heap[nb].has_next;
            if (heap[nb].has_next && heap[nb].next < STORE) begin
               heap[heap[nb].next].prev = 16'(cur);
               heap[heap[nb].next].has_prev = 1;
            end
            n_blocks = n_blocks - 13'd1;
         end
      end
      return mk(ST_OK, 16'd0);
   endfunction

   // Appends one request word to the stimulus queue.
   function automatic void push_word(logic op, logic [15:0] len, logic [15:0] off);
      request_type r;
      r.op = op; r.len = len; r.off = off;
      pending_words.push_back(r);
   endfunction

   function automatic logic [15:0] random_len();
      case ($urandom_range(0, 9))
         0: return 16'($urandom());
         1: return 16'($urandom_range(0, 4));
         2, 3: return 16'($urandom_range(1, 1024));
         default: return 16'($urandom_range(1, 200));
      endcase
   endfunction

   // Driver: pops one word at a time, changes inputs at the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (pending_words.size() > 0 && !pause_req &&
                (quiet_phase || $urandom_range(0, 99) >= 31)) begin
               req_valid <= 1'b1;
               req_operation <= pending_words[0].op;
               req_request_length <= pending_words[0].len;
               req_data_offset <= pending_words[0].off;
               void'(pending_words.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random ready, plus a long hold-off counted here when requested.
   always @(negedge clock) begin
      if (!reset) begin
         if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= quiet_phase || $urandom_range(0, 99) >= 31;
         end
      end
   end

   // Monitor: predicts on request acceptance, checks on result acceptance.
   always @(posedge clock) begin
      outcome_type exp_o;
      req_ready_seen <= 0;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            req_ready_seen <= 1;
            if (req_operation == OP_ALLOC) exp_o = heap_alloc(req_request_length);
            else exp_o = heap_free(req_data_offset);
            if (exp_o.status == ST_OK && req_operation == OP_ALLOC)
               live_offsets.push_back(exp_o.granted);
            expected_outcomes.push_back(exp_o);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               $error("result word with no expectation waiting");
               fail_count++;
            end else begin
               exp_o = expected_outcomes.pop_front();
               if (rsp_status !== exp_o.status) begin
                  $error("status: expected %0d, actual %0d", exp_o.status, rsp_status);
                  fail_count++;
               end
               if (rsp_granted_offset !== exp_o.granted) begin
                  $error("granted_offset: expected %0d, actual %0d",
                         exp_o.granted, rsp_granted_offset);
                  fail_count++;
               end
               if (rsp_block_count !== exp_o.count) begin
                  $error("block_count: expected %0d, actual %0d",
                         exp_o.count, rsp_block_count);
                  fail_count++;
               end
               if (rsp_used_bytes !== exp_o.used) begin
                  $error("used_bytes: expected %0d, actual %0d", exp_o.used, rsp_used_bytes);
                  fail_count++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic void random_batch(int n);
      int k;
      logic [15:0] o;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 50) begin
            push_word(OP_ALLOC, random_len(), 16'($urandom()));
         end else if (k < 85) begin
            // free a previously granted block; the caller may patch the target in after the push
            push_word(OP_FREE, 16'($urandom()), 16'hFFFF);
         end else if (k < 93) begin
            o = 16'($urandom_range(0, STORE + 16));
            push_word(OP_FREE, 16'($urandom()), o);
         end else begin
            push_word(OP_FREE, 16'($urandom()), 16'($urandom()));
         end
      end
   endfunction

   task automatic drain();
      wait (pending_words.size() == 0);
      @(posedge clock);
      while (expected_outcomes.size() != 0 || req_valid) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < STORE; i++) heap[i] = '{default: 0};
      heap[0].mark = MARK;
      heap[0].size = 16'(STORE - HDR);
      n_blocks = 13'd1;
      n_used = 16'd0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: length extremes, exact fit, rounding, frees of every kind
      push_word(OP_ALLOC, 16'd0, 16'hFFFF);
      push_word(OP_ALLOC, 16'd4096, 16'h0000);
      push_word(OP_ALLOC, 16'hFFFF, 16'h5555);
      push_word(OP_ALLOC, 16'd1, 16'hAAAA);
      push_word(OP_ALLOC, 16'd5, 16'd0);
      push_word(OP_ALLOC, 16'd4095, 16'd0);     // no fit
      push_word(OP_FREE, 16'hFFFF, 16'd0);      // below header
      push_word(OP_FREE, 16'd0, 16'd4097);      // beyond pool
      push_word(OP_FREE, 16'd0, 16'hFFFF);
      push_word(OP_FREE, 16'd0, 16'd13);        // no header there
      push_word(OP_FREE, 16'd0, 16'd28);        // second block: merges with the free tail
      push_word(OP_FREE, 16'd0, 16'd12);        // first block
      push_word(OP_FREE, 16'd0, 16'd12);        // double free
      push_word(OP_FREE, 16'd0, 16'd28);        // stale header after merge
      push_word(OP_ALLOC, 16'd8, 16'd0);
      push_word(OP_ALLOC, 16'd8, 16'd0);
      push_word(OP_ALLOC, 16'd8, 16'd0);
      push_word(OP_FREE, 16'd0, 16'd32);        // middle, no merge
      push_word(OP_FREE, 16'd0, 16'd12);        // merge with next
      push_word(OP_FREE, 16'd0, 16'd52);        // merge both sides
      push_word(OP_ALLOC, 16'd4072, 16'd0);     // leaves zero-size remainder
      push_word(OP_FREE, 16'd0, 16'd12);
      push_word(OP_FREE, 16'd0, 16'd4096);      // top of pool
      drain();

      // random, with free targets patched from the live list as the sender runs
      for (int phase = 0; phase < 6; phase++) begin
         quiet_phase = (phase == 2);
         for (int i = 0; i < 250; i++) begin
            random_batch(1);
            if (pending_words[$].off == 16'hFFFF && pending_words[$].op == OP_FREE) begin
               if (live_offsets.size() > 0)
                  pending_words[$].off = live_offsets[$urandom_range(0,
                                                      live_offsets.size() - 1)];
               else
                  pending_words[$].op = OP_ALLOC;
            end
            wait (pending_words.size() < 2);
         end
         if (phase == 3) begin
            hold_requests++;           // receiver holds off while words keep coming
            random_batch(20);
         end
         if (phase == 1) begin
            pause_req = 1;             // sender waits for every result
            while (expected_outcomes.size() != 0 || req_valid) @(posedge clock);
            pause_req = 0;
         end
      end
      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
